// ===== rtl/csn_pkg.sv =====
// Shared constants and width helpers for the cylinder surface normal unit.
package csn_pkg;

  // Offset magnitudes are prescaled so the largest one lies in [2^29, 2^30).
  localparam int NORM_BITS = 30;
  // Sum of three squared prescaled magnitudes, and its integer square root.
  localparam int SUM_W     = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = SUM_W / 2;

  // Width of the signed perpendicular offset w = v - floor(t * d).
  function automatic int offset_width(input int cw, input int fb);
    int vw;
    int rw;
    vw = cw + 1;
    rw = vw + 4 + (fb + 2) - fb;
    return ((vw > rw) ? vw : rw) + 1;
  endfunction

endpackage

// ===== rtl/csn_offset.sv =====
// Offset pipeline: v = hit - axis point, projection on the axis, perpendicular offset magnitudes.
module csn_offset #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int WW = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] ap [3],
  input  logic signed [CW-1:0] hp [3],
  input  logic signed [FB+1:0] dir [3],
  input  logic                 inv,
  output logic                 out_valid,
  output logic [WW-1:0]        mag [3],
  output logic [2:0]           neg,
  output logic                 out_inv,
  output logic [WW-1:0]        any
);

  localparam int DW = FB + 2;
  localparam int VW = CW + 1;
  localparam int PW = VW + DW;
  localparam int SW = PW + 2;
  localparam int TW = SW - FB;
  localparam int QW = TW + DW;
  localparam int RW = QW - FB;

  logic [3:0] vld;

  logic signed [VW-1:0] v1 [3];
  logic signed [DW-1:0] d1 [3];
  logic                 inv1;
  logic signed [PW-1:0] pr2 [3];
  logic signed [VW-1:0] v2 [3];
  logic signed [DW-1:0] d2 [3];
  logic                 inv2;
  logic signed [TW-1:0] t3;
  logic signed [VW-1:0] v3 [3];
  logic signed [DW-1:0] d3 [3];
  logic                 inv3;
  logic signed [QW-1:0] q4 [3];
  logic signed [VW-1:0] v4 [3];
  logic                 inv4;

  logic signed [SW-1:0] dot;
  logic signed [RW-1:0] pf [3];
  logic signed [WW-1:0] w [3];
  logic [WW-1:0]        mag_next [3];

  always_comb begin
    dot = SW'(pr2[0]) + SW'(pr2[1]) + SW'(pr2[2]);
    for (int i = 0; i < 3; i++) begin
      pf[i] = q4[i][QW-1:FB];
      w[i] = WW'(v4[i]) - WW'(pf[i]);
      mag_next[i] = w[i][WW-1] ? WW'(-w[i]) : WW'(w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        v1[i] <= VW'(hp[i]) - VW'(ap[i]);
        d1[i] <= dir[i];
        pr2[i] <= v1[i] * d1[i];
        v2[i] <= v1[i];
        d2[i] <= d1[i];
        v3[i] <= v2[i];
        d3[i] <= d2[i];
        q4[i] <= t3 * d3[i];
        v4[i] <= v3[i];
        mag[i] <= mag_next[i];
        neg[i] <= w[i][WW-1];
      end
      inv1 <= inv;
      inv2 <= inv1;
      t3 <= dot[SW-1:FB];
      inv3 <= inv2;
      inv4 <= inv3;
      out_inv <= inv4;
      any <= mag_next[0] | mag_next[1] | mag_next[2];
    end
  end

endmodule

// ===== rtl/csn_norm.sv =====
// Prescale of the offset magnitudes and the sum of their squares.
module csn_norm #(
  parameter int WW = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [WW-1:0]                 mag [3],
  input  logic [2:0]                    neg,
  input  logic                          inv,
  input  logic [WW-1:0]                 any,
  output logic                          out_valid,
  output logic [csn_pkg::SUM_W-1:0]     sum,
  output logic [csn_pkg::NORM_BITS-1:0] mn [3],
  output logic [2:0]                    out_neg,
  output logic                          out_inv,
  output logic                          zero
);

  localparam int NB  = csn_pkg::NORM_BITS;
  localparam int PSW = $clog2(WW);
  localparam int XW  = WW + NB;
  localparam int SHW = $clog2(XW + 1);

  logic [2:0] vld;

  logic [PSW-1:0] pos_c;
  logic [SHW-1:0] rsh_c, lsh_c;

  logic [WW-1:0]  ma [3];
  logic [SHW-1:0] rsh, lsh;
  logic [2:0]     neg_a, neg_b, neg_c;
  logic           inv_a, inv_b, inv_c;
  logic           zero_a, zero_b, zero_c;

  logic [XW-1:0]   wide [3];
  logic [NB-1:0]   mb [3];
  logic [NB-1:0]   mc [3];
  logic [2*NB-1:0] sq [3];

  // The top set bit of the OR of the magnitudes is the top set bit of the largest one.
  always_comb begin
    pos_c = '0;
    for (int k = 0; k < WW; k++) begin
      if (any[k]) pos_c = PSW'(k);
    end
    rsh_c = '0;
    lsh_c = '0;
    if (int'(pos_c) > NB - 1) begin
      rsh_c = SHW'(int'(pos_c) - (NB - 1));
    end else begin
      lsh_c = SHW'((NB - 1) - int'(pos_c));
    end
    for (int i = 0; i < 3; i++) begin
      wide[i] = (XW'(ma[i]) << lsh) >> rsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] <= mag[i];
        mb[i] <= wide[i][NB-1:0];
        sq[i] <= (2*NB)'(mb[i]) * (2*NB)'(mb[i]);
        mc[i] <= mb[i];
        mn[i] <= mc[i];
      end
      rsh <= rsh_c;
      lsh <= lsh_c;
      neg_a <= neg;
      inv_a <= inv;
      zero_a <= (any == '0);
      neg_b <= neg_a;
      inv_b <= inv_a;
      zero_b <= zero_a;
      neg_c <= neg_b;
      inv_c <= inv_b;
      zero_c <= zero_b;
      sum <= csn_pkg::SUM_W'(sq[0]) + csn_pkg::SUM_W'(sq[1]) + csn_pkg::SUM_W'(sq[2]);
      out_neg <= neg_c;
      out_inv <= inv_c;
      zero <= zero_c;
    end
  end

endmodule

// ===== rtl/csn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side word carried along.
module csn_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [csn_pkg::SUM_W-1:0]  x,
  input  logic [SIDE_W-1:0]          side,
  output logic                       out_valid,
  output logic [csn_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int RB  = csn_pkg::ROOT_W;
  localparam int RMW = csn_pkg::SUM_W + 2;

  logic [RMW-1:0]    rem_q  [RB];
  logic [RB-1:0]     root_q [RB];
  logic [SIDE_W-1:0] side_q [RB];
  logic              vld_q  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int B = RB - 1 - k;
    logic [RMW-1:0]    rem_in;
    logic [RB-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RMW-1:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = RMW'(x);
      assign root_in = '0;
      assign side_in = side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b), with the low bits of r still clear.
    assign trial = (RMW'(root_in) << (B + 1)) | (RMW'(1) << (2 * B));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k]  <= ge ? rem_in - trial : rem_in;
        root_q[k] <= root_in | (RB'(ge) << B);
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[RB-1];
  assign root      = root_q[RB-1];
  assign out_side  = side_q[RB-1];

endmodule

// ===== rtl/csn_div.sv =====
// Three-lane pipelined restoring divider for the rounded normal components.
module csn_div #(
  parameter int FB     = 16,
  parameter int SIDE_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [csn_pkg::NORM_BITS-1:0] mag [3],
  input  logic [csn_pkg::ROOT_W-1:0]    den,
  input  logic [SIDE_W-1:0]             side,
  output logic                          out_valid,
  output logic [FB+1:0]                 quo [3],
  output logic [SIDE_W-1:0]             out_side
);

  localparam int QB = FB + 2;
  localparam int DN = csn_pkg::ROOT_W;
  localparam int RW = DN + QB + 1;

  logic [RW-1:0]     rem_q  [QB][3];
  logic [QB-1:0]     quo_q  [QB][3];
  logic [DN-1:0]     den_q  [QB];
  logic [SIDE_W-1:0] side_q [QB];
  logic              vld_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [RW-1:0]     rem_in [3];
    logic [QB-1:0]     quo_in [3];
    logic [DN-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RW-1:0]     dd;
    logic [2:0]        ge;

    if (k == 0) begin : g_first
      // Numerator is mag * 2^FB plus half the length, for round half up.
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = RW'({mag[i], {FB{1'b0}}}) + RW'(den >> 1);
        assign quo_in[i] = '0;
      end
      assign den_in  = den;
      assign side_in = side;
      assign vld_in  = in_valid;
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = rem_q[k-1][i];
        assign quo_in[i] = quo_q[k-1][i];
      end
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign dd = RW'(den_in) << B;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (rem_in[i] >= dd);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= ge[i] ? rem_in[i] - dd : rem_in[i];
          quo_q[k][i] <= quo_in[i] | (QB'(ge[i]) << B);
        end
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[QB-1];
  assign out_side  = side_q[QB-1];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign quo[i] = quo_q[QB-1][i];
  end

endmodule

// ===== rtl/cylinder_surface_normal_unit.sv =====
// Top level of the cylinder surface normal unit.
// Each input transaction carries an axis point, a hit point, a unit axis
// direction and an invert flag; each one yields exactly one output transaction
// with the unit normal from the axis to the hit and a degenerate flag.
// Both channels use valid and stall; a transaction moves when valid is high
// and stall is low. One transaction is accepted every cycle while in_stall is low.
// The pipeline has five offset stages, four
// prescale and sum-of-squares stages, one square root stage per root bit
// (31), one divider stage per quotient bit, and the output register.
// Reset empties the pipeline; no output transaction is pending after it.
// When the receiver stalls a pending result, the whole pipeline holds and
// in_stall rises in the same cycle, so nothing is lost or repeated.
module cylinder_surface_normal_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] axis_point_x,
  input  logic signed [COORD_WIDTH-1:0] axis_point_y,
  input  logic signed [COORD_WIDTH-1:0] axis_point_z,
  input  logic signed [COORD_WIDTH-1:0] hit_x,
  input  logic signed [COORD_WIDTH-1:0] hit_y,
  input  logic signed [COORD_WIDTH-1:0] hit_z,
  input  logic signed [FRAC_BITS+1:0]   axis_dir_x,
  input  logic signed [FRAC_BITS+1:0]   axis_dir_y,
  input  logic signed [FRAC_BITS+1:0]   axis_dir_z,
  input  logic                          invert,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FRAC_BITS+1:0]   normal_x,
  output logic signed [FRAC_BITS+1:0]   normal_y,
  output logic signed [FRAC_BITS+1:0]   normal_z,
  output logic                          degenerate
);

  localparam int WW  = csn_pkg::offset_width(COORD_WIDTH, FRAC_BITS);
  localparam int NB  = csn_pkg::NORM_BITS;
  localparam int QB  = FRAC_BITS + 2;
  localparam int SQS = 3 * NB + 5;
  localparam int DVS = 5;

  logic adv;

  logic signed [COORD_WIDTH-1:0] ap [3];
  logic signed [COORD_WIDTH-1:0] hp [3];
  logic signed [FRAC_BITS+1:0]   dir [3];

  logic          off_valid;
  logic [WW-1:0] off_mag [3];
  logic [2:0]    off_neg;
  logic          off_inv;
  logic [WW-1:0] off_any;

  logic                          nrm_valid;
  logic [csn_pkg::SUM_W-1:0]     nrm_sum;
  logic [NB-1:0]                 nrm_mag [3];
  logic [2:0]                    nrm_neg;
  logic                          nrm_inv;
  logic                          nrm_zero;

  logic                       sq_valid;
  logic [csn_pkg::ROOT_W-1:0] sq_root;
  logic [SQS-1:0]             sq_side;
  logic [NB-1:0]              sq_mag [3];

  logic          dv_valid;
  logic [QB-1:0] dv_quo [3];
  logic [DVS-1:0] dv_side;

  logic [QB-1:0] q_clamp [3];
  logic [QB-1:0] n_next [3];

  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  assign ap[0]  = axis_point_x;
  assign ap[1]  = axis_point_y;
  assign ap[2]  = axis_point_z;
  assign hp[0]  = hit_x;
  assign hp[1]  = hit_y;
  assign hp[2]  = hit_z;
  assign dir[0] = axis_dir_x;
  assign dir[1] = axis_dir_y;
  assign dir[2] = axis_dir_z;

  csn_offset #(
    .CW (COORD_WIDTH),
    .FB (FRAC_BITS),
    .WW (WW)
  ) u_offset (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .ap        (ap),
    .hp        (hp),
    .dir       (dir),
    .inv       (invert),
    .out_valid (off_valid),
    .mag       (off_mag),
    .neg       (off_neg),
    .out_inv   (off_inv),
    .any       (off_any)
  );

  csn_norm #(
    .WW (WW)
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (off_valid),
    .mag       (off_mag),
    .neg       (off_neg),
    .inv       (off_inv),
    .any       (off_any),
    .out_valid (nrm_valid),
    .sum       (nrm_sum),
    .mn        (nrm_mag),
    .out_neg   (nrm_neg),
    .out_inv   (nrm_inv),
    .zero      (nrm_zero)
  );

  csn_sqrt #(
    .SIDE_W (SQS)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (nrm_valid),
    .x         (nrm_sum),
    .side      ({nrm_mag[0], nrm_mag[1], nrm_mag[2], nrm_neg, nrm_inv, nrm_zero}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign sq_mag[0] = sq_side[SQS-1 -: NB];
  assign sq_mag[1] = sq_side[SQS-1-NB -: NB];
  assign sq_mag[2] = sq_side[SQS-1-2*NB -: NB];

  csn_div #(
    .FB     (FRAC_BITS),
    .SIDE_W (DVS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .mag       (sq_mag),
    .den       (sq_root),
    .side      (sq_side[DVS-1:0]),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_side  (dv_side)
  );

  // Side word order is neg[2:0], invert, zero; neg[0] belongs to x.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_clamp[i] = (dv_quo[i] > (QB'(1) << FRAC_BITS)) ? (QB'(1) << FRAC_BITS) : dv_quo[i];
      n_next[i]  = (dv_side[2+i] ^ dv_side[1]) ? QB'(-q_clamp[i]) : q_clamp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x   <= dv_side[0] ? '0 : n_next[0];
      normal_y   <= dv_side[0] ? '0 : n_next[1];
      normal_z   <= dv_side[0] ? '0 : n_next[2];
      degenerate <= dv_side[0];
    end
  end

endmodule
